// ===== rtl/asa_pkg.sv =====
`timescale 1ns / 1ps
package asa_pkg;

  localparam int REGION_BYTES = 65536;
  localparam int MAX_ENTRIES  = 64;

  localparam int ADDR_W     = 32;
  localparam int SIZE_W     = 17;
  localparam int ALIGN_W    = 16;
  localparam int CMD_W      = 2;
  localparam int STATUS_W   = 3;
  localparam int OFFSET_W   = $clog2(REGION_BYTES + 1);
  localparam int COUNT_W    = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W      = $clog2(MAX_ENTRIES);
  localparam int DIVIDEND_W = ADDR_W + 1;
  localparam int DIV_STEPS  = DIVIDEND_W;
  localparam int STEP_CNT_W = $clog2(DIV_STEPS + 1);
  localparam int TOTAL_W    = SIZE_W + 1;

  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [ALIGN_W-1:0] rem;
  } div_rsp_t;

endpackage

// ===== rtl/aligned_stack_allocator.sv =====
`timescale 1ns / 1ps
// Aligned stack allocator: bump allocation with a stack of block sizes.
// An allocate runs through the bit-serial remainder unit (33 divider steps), the space
// check and the output state; a pop goes through the pop state, while clear and
// rejected commands go straight to the output state. One command is in flight, and a
// result left waiting holds up the command behind it. Reset (synchronous, rst_n low)
// clears the state, output valid, offset, entry count and base address.
module aligned_stack_allocator (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,  // block_size [16:0], alignment [32:17], zero [39:33]
  input  logic [1:0]  in_tuser,  // cmd [1:0]
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata, // address [31:0], entries_used [38:32], bytes_used [55:39]
  output logic [2:0]  out_tuser, // status [2:0]
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import asa_pkg::*;

  // Controller states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_POP   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  localparam logic [2:0] REG_BASE_ADDR = 3'd0;

  logic [2:0]            state_r, state_nxt;
  logic [ADDR_W-1:0]     base_r, base_nxt;
  logic [OFFSET_W-1:0]   offset_r, offset_nxt;
  logic [COUNT_W-1:0]    count_r, count_nxt;
  logic [SIZE_W-1:0]     size_r, size_nxt;
  logic [ALIGN_W-1:0]    align_r, align_nxt;
  logic [DIVIDEND_W-1:0] a_r, a_nxt;
  logic [STATUS_W-1:0]   res_status_r, res_status_nxt;
  logic [ADDR_W-1:0]     res_addr_r, res_addr_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [55:0]           out_data_r, out_data_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;

  logic [CMD_W-1:0]      in_cmd;
  logic [SIZE_W-1:0]     in_size;
  logic [ALIGN_W-1:0]    in_align;
  logic                  in_beat;
  logic                  cfg_write;
  logic                  div_start;
  div_rsp_t              div_rsp;

  logic [ALIGN_W-1:0]    pad;
  logic [TOTAL_W-1:0]    total;
  logic [TOTAL_W-1:0]    room;
  logic [ADDR_W-1:0]     aligned_addr;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_addr;
  logic [SIZE_W-1:0]     ram_rdata;
  logic [COUNT_W-1:0]    count_dec;
  logic [OFFSET_W-1:0]   top_size;

  assign in_cmd   = in_tuser;
  assign in_size  = in_tdata[SIZE_W-1:0];
  assign in_align = in_tdata[SIZE_W+ALIGN_W-1:SIZE_W];

  // Only one command is held at a time; a result still waiting in the output
  // register does not stop the next command from being taken.
  assign in_tready = (state_r == S_IDLE);
  assign in_beat   = in_tvalid && in_tready;

  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr == REG_BASE_ADDR) ? base_r : '0;

  // The exact, unwrapped current address feeds the remainder unit.
  assign a_nxt     = {1'b0, base_r} + {{(DIVIDEND_W-OFFSET_W){1'b0}}, offset_r};
  assign div_start = in_beat && (in_cmd == CMD_ALLOC) && (in_size != '0) && (in_align != '0);

  asa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (a_nxt),
    .divisor  (in_align),
    .rsp      (div_rsp)
  );

  // Padding up to the next multiple of the alignment, and the room left.
  assign pad          = (div_rsp.rem == '0) ? '0 : (align_r - div_rsp.rem);
  assign total        = {{(TOTAL_W-ALIGN_W){1'b0}}, pad} + {{(TOTAL_W-SIZE_W){1'b0}}, size_r};
  assign room         = TOTAL_W'(REGION_BYTES) - {{(TOTAL_W-OFFSET_W){1'b0}}, offset_r};
  assign aligned_addr = a_r[ADDR_W-1:0] + {{(ADDR_W-ALIGN_W){1'b0}}, pad};

  // The stack is written at the free slot on a push, and read at the top slot
  // in every other cycle, so the top is ready the cycle after a pop is taken.
  assign count_dec = count_r - 1'b1;
  assign ram_addr  = (state_r == S_CHECK) ? count_r[IDX_W-1:0] : count_dec[IDX_W-1:0];
  assign ram_we    = (state_r == S_CHECK) && (total <= room) &&
                     (count_r < COUNT_W'(MAX_ENTRIES));
  assign top_size  = OFFSET_W'(ram_rdata);

  asa_ram #(
    .WIDTH (SIZE_W),
    .DEPTH (MAX_ENTRIES)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (total[SIZE_W-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    base_nxt       = base_r;
    offset_nxt     = offset_r;
    count_nxt      = count_r;
    size_nxt       = size_r;
    align_nxt      = align_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;

    if (cfg_write && (cfg_paddr == REG_BASE_ADDR)) begin
      base_nxt = cfg_pwdata;
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          size_nxt       = in_size;
          align_nxt      = in_align;
          res_addr_nxt   = '0;
          res_status_nxt = ST_OK;
          state_nxt      = S_OUT;
          case (in_cmd)
            CMD_ALLOC: begin
              if ((in_size == '0) || (in_align == '0)) begin
                res_status_nxt = ST_INVALID;
              end else begin
                state_nxt = S_DIV;
              end
            end
            CMD_POP: begin
              if (count_r == '0) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                state_nxt = S_POP;
              end
            end
            CMD_CLEAR: begin
              count_nxt  = '0;
              offset_nxt = '0;
            end
            default: begin
              res_status_nxt = ST_INVALID;
            end
          endcase
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        // The space check comes before the stack-full check.
        state_nxt = S_OUT;
        if (total > room) begin
          res_status_nxt = ST_NO_SPACE;
        end else if (count_r >= COUNT_W'(MAX_ENTRIES)) begin
          res_status_nxt = ST_FULL;
        end else begin
          res_addr_nxt = aligned_addr;
          count_nxt    = count_r + 1'b1;
          offset_nxt   = offset_r + total[OFFSET_W-1:0];
        end
      end
      S_POP: begin
        // The top entry can never exceed the offset; saturate all the same.
        offset_nxt = (top_size > offset_r) ? '0 : (offset_r - top_size);
        count_nxt  = count_dec;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_data_nxt   = {offset_r, count_r, res_addr_r};
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      base_r      <= '0;
      offset_r    <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      offset_r    <= offset_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    size_r       <= size_nxt;
    align_r      <= align_nxt;
    a_r          <= (state_r == S_IDLE) ? a_nxt : a_r;
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_W'(MAX_ENTRIES))
    else $error("entry count beyond stack depth");

  a_offset_bound: assert property (@(posedge clk) disable iff (!rst_n)
    offset_r <= OFFSET_W'(REGION_BYTES))
    else $error("offset beyond region");

  a_reject_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != ST_OK)) |-> (out_data_r[ADDR_W-1:0] == '0))
    else $error("address not zero on a rejected command");

  a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP) |=> (count_r == $past(count_dec)))
    else $error("pop did not drop one entry");

  a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.busy |-> (state_r == S_DIV))
    else $error("remainder unit busy outside the divide state");
`endif

endmodule

// ===== rtl/asa_ram.sv =====
`timescale 1ns / 1ps
module asa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/asa_div.sv =====
`timescale 1ns / 1ps
module asa_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [asa_pkg::DIVIDEND_W-1:0] dividend,
  input  logic [asa_pkg::ALIGN_W-1:0]    divisor,
  output asa_pkg::div_rsp_t            rsp
);
  import asa_pkg::*;

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [STEP_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIVIDEND_W-1:0] shift_r, shift_nxt;
  logic [ALIGN_W-1:0]    rem_r, rem_nxt;
  logic [ALIGN_W-1:0]    divisor_r, divisor_nxt;
  logic [ALIGN_W:0]      trial;
  logic [ALIGN_W:0]      diff;

  // One dividend bit enters the partial remainder each cycle while busy.
  always_comb begin
    trial       = {rem_r, shift_r[DIVIDEND_W-1]};
    diff        = trial - {1'b0, divisor_r};
    busy_nxt    = busy_r;
    done_nxt    = 1'b0;
    cnt_nxt     = cnt_r;
    shift_nxt   = shift_r;
    rem_nxt     = rem_r;
    divisor_nxt = divisor_r;
    if (start) begin
      busy_nxt    = 1'b1;
      cnt_nxt     = '0;
      shift_nxt   = dividend;
      rem_nxt     = '0;
      divisor_nxt = divisor;
    end else if (busy_r) begin
      shift_nxt = {shift_r[DIVIDEND_W-2:0], 1'b0};
      rem_nxt   = (trial >= {1'b0, divisor_r}) ? diff[ALIGN_W-1:0] : trial[ALIGN_W-1:0];
      cnt_nxt   = cnt_r + 1'b1;
      if (cnt_r == STEP_CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    shift_r   <= shift_nxt;
    rem_r     <= rem_nxt;
    divisor_r <= divisor_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

// ===== sim/tb_aligned_stack_allocator.sv =====
`timescale 1ns / 1ps
module tb_aligned_stack_allocator;
  import asa_pkg::*;

  // The spare command code, which the block must reject without touching its state.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  // The only register, base_address, is register 0 at byte address 0.
  localparam logic [2:0] REG_BASE_ADDRESS = 3'd0;
  // No beat on either channel for this many cycles means the block has hung.
  localparam int WATCHDOG_LIMIT = 5000;
  // Allocate is the slowest command, so this covers any straggler.
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_PER_PHASE = 100;

  // What one result beat carries, in the predictor's terms.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   address;
    logic [COUNT_W-1:0]  entries;
    logic [OFFSET_W-1:0] bytes;
  } alloc_result_t;

  // One row of the directed table. Where "typed" is set, the expected result is
  // taken from the row itself rather than from the predictor.
  typedef struct {
    logic [CMD_W-1:0]    cmd;
    logic [SIZE_W-1:0]   size;
    logic [ALIGN_W-1:0]  align;
    int                  reps;
    bit                  typed;
    logic [STATUS_W-1:0] want_status;
    logic [ADDR_W-1:0]   want_address;
    logic [COUNT_W-1:0]  want_entries;
    logic [OFFSET_W-1:0] want_bytes;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;  // block_size [16:0], alignment [32:17], zero [39:33]
  logic [1:0]  in_tuser = '0;  // cmd [1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;      // address [31:0], entries_used [38:32], bytes_used [55:39]
  logic [2:0]  out_tuser;      // status [2:0]
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // The predictor's own copy of the allocator state and of the base address.
  logic [ADDR_W-1:0]   base_addr = '0;
  logic [OFFSET_W-1:0] used_bytes = '0;
  logic [COUNT_W-1:0]  entry_cnt = '0;
  logic [TOTAL_W-1:0]  block_sizes [MAX_ENTRIES];

  // Results owed by the block, oldest first.
  alloc_result_t owed_results [$];

  int  fail_count = 0;
  int  result_beats = 0;
  int  quiet_cycles = 0;
  int  rx_hold = 0;
  bit  long_hold_done = 1'b0;
  bit  rx_steady = 1'b0;
  bit  tx_steady = 1'b0;

  // Directed part, run with the reset base address of zero. Rows without a typed
  // answer depend on padding arithmetic and are left to the predictor.
  directed_row_t directed_rows [22] = '{
    // Pop and argument checks on an empty allocator.
    '{CMD_POP,    17'd0,       16'd0,      1, 1'b1, ST_EMPTY,   32'd0, 7'd0,  17'd0},
    '{CMD_ALLOC,  17'd0,       16'd1,      1, 1'b1, ST_INVALID, 32'd0, 7'd0,  17'd0},
    '{CMD_ALLOC,  17'd1,       16'd0,      1, 1'b1, ST_INVALID, 32'd0, 7'd0,  17'd0},
    '{CMD_UNUSED, 17'h1FFFF,   16'hFFFF,   1, 1'b1, ST_INVALID, 32'd0, 7'd0,  17'd0},
    '{CMD_CLEAR,  17'd0,       16'd0,      1, 1'b1, ST_OK,      32'd0, 7'd0,  17'd0},
    // The whole region in one block, then nothing more fits.
    '{CMD_ALLOC,  17'd65536,   16'd1,      1, 1'b1, ST_OK,      32'd0, 7'd1,  17'd65536},
    '{CMD_ALLOC,  17'd1,       16'd1,      1, 1'b1, ST_NO_SPACE,32'd0, 7'd1,  17'd65536},
    '{CMD_POP,    17'd0,       16'd0,      1, 1'b1, ST_OK,      32'd0, 7'd0,  17'd0},
    // Largest alignment: no padding at offset zero, nearly a full region after.
    '{CMD_ALLOC,  17'd1,       16'hFFFF,   1, 1'b1, ST_OK,      32'd0, 7'd1,  17'd1},
    '{CMD_ALLOC,  17'd100,     16'hFFFF,   1, 1'b0, ST_OK,      32'd0, 7'd0,  17'd0},
    '{CMD_ALLOC,  17'd3,       16'd8,      1, 1'b0, ST_OK,      32'd0, 7'd0,  17'd0},
    '{CMD_ALLOC,  17'h1FFFF,   16'hFFFF,   1, 1'b0, ST_OK,      32'd0, 7'd0,  17'd0},
    '{CMD_POP,    17'd0,       16'd0,      1, 1'b0, ST_OK,      32'd0, 7'd0,  17'd0},
    '{CMD_POP,    17'd0,       16'd0,      1, 1'b0, ST_OK,      32'd0, 7'd0,  17'd0},
    '{CMD_POP,    17'd0,       16'd0,      1, 1'b1, ST_EMPTY,   32'd0, 7'd0,  17'd0},
    // Fill the size stack, then hit it when full. Lack of space wins over a full
    // stack when both apply.
    '{CMD_ALLOC,  17'd16,      16'd4,     64, 1'b0, ST_OK,      32'd0, 7'd0,  17'd0},
    '{CMD_ALLOC,  17'd1,       16'd1,      1, 1'b1, ST_FULL,    32'd0, 7'd64, 17'd1024},
    '{CMD_ALLOC,  17'd64513,   16'd1,      1, 1'b1, ST_NO_SPACE,32'd0, 7'd64, 17'd1024},
    '{CMD_POP,    17'd0,       16'd0,      1, 1'b0, ST_OK,      32'd0, 7'd0,  17'd0},
    '{CMD_CLEAR,  17'd0,       16'd0,      1, 1'b1, ST_OK,      32'd0, 7'd0,  17'd0},
    '{CMD_ALLOC,  17'h10000,   16'h8000,   1, 1'b1, ST_OK,      32'd0, 7'd1,  17'd65536},
    '{CMD_CLEAR,  17'd0,       16'd0,      1, 1'b0, ST_OK,      32'd0, 7'd0,  17'd0}
  };

  // Base addresses for the random phases, extremes first; two are drawn at random.
  logic [31:0] phase_bases [8] = '{
    32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_0001, 32'h0,
    32'h0000_0003, 32'h0,         32'hFFFF_FFF0, 32'h0
  };

  aligned_stack_allocator dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Works out the result of one accepted command and advances the predicted state.
  // The padding is taken from the exact 33-bit sum of base and offset; only the
  // returned address wraps to 32 bits. Every check comes before any state change.
  function automatic alloc_result_t predict_allocation(logic [CMD_W-1:0] cmd,
                                                       logic [SIZE_W-1:0] size,
                                                       logic [ALIGN_W-1:0] align);
    alloc_result_t       r;
    logic [ADDR_W:0]     start;
    logic [63:0]         rem;
    logic [OFFSET_W-1:0] pad;
    logic [TOTAL_W-1:0]  total;
    logic [TOTAL_W-1:0]  room;
    logic [TOTAL_W-1:0]  top;
    r.status  = ST_OK;
    r.address = '0;
    case (cmd)
      CMD_ALLOC: begin
        if (size == 0 || align == 0) begin
          r.status = ST_INVALID;
        end else begin
          start = {1'b0, base_addr} + (ADDR_W + 1)'(used_bytes);
          rem   = 64'(start) % 64'(align);
          pad   = (rem == 0) ? '0 : OFFSET_W'(64'(align) - rem);
          total = TOTAL_W'(pad) + TOTAL_W'(size);
          room  = TOTAL_W'(REGION_BYTES) - TOTAL_W'(used_bytes);
          if (total > room) begin
            r.status = ST_NO_SPACE;
          end else if (entry_cnt >= MAX_ENTRIES) begin
            r.status = ST_FULL;
          end else begin
            r.address = start[ADDR_W-1:0] + ADDR_W'(pad);
            block_sizes[entry_cnt[IDX_W-1:0]] = total;
            entry_cnt  = entry_cnt + 1'b1;
            used_bytes = used_bytes + total[OFFSET_W-1:0];
          end
        end
      end
      CMD_POP: begin
        if (entry_cnt == 0) begin
          r.status = ST_EMPTY;
        end else begin
          top = block_sizes[IDX_W'(entry_cnt - 1'b1)];
          used_bytes = (top > TOTAL_W'(used_bytes)) ? '0 : used_bytes - top[OFFSET_W-1:0];
          entry_cnt  = entry_cnt - 1'b1;
        end
      end
      CMD_CLEAR: begin
        entry_cnt  = '0;
        used_bytes = '0;
      end
      default: begin
        r.status = ST_INVALID;
      end
    endcase
    r.entries = entry_cnt;
    r.bytes   = used_bytes;
    return r;
  endfunction

  // Offers one command beat and waits for it to be taken. tvalid is left high so
  // that a following beat can go straight out; lowering it is the job of the gap.
  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [SIZE_W-1:0] size,
                              input logic [ALIGN_W-1:0] align, input bit typed,
                              input alloc_result_t typed_result);
    alloc_result_t predicted;
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, align, size};
    in_tuser  <= cmd;
    do @(posedge clk); while (!in_tready);
    predicted = predict_allocation(cmd, size, align);
    owed_results.push_back(typed ? typed_result : predicted);
  endtask

  // Idle time after a beat: mostly none or a short gap, now and then a long gap, and none in the steady phase.
  task automatic sender_gap();
    int pick;
    int len;
    pick = $urandom_range(0, 99);
    if (tx_steady || pick < 55) begin
      len = 0;
    end else if (pick < 90) begin
      len = $urandom_range(1, 4);
    end else begin
      len = $urandom_range(10, 50);
    end
    if (len > 0) begin
      in_tvalid <= 1'b0;
      repeat (len) @(posedge clk);
    end
  endtask

  // One random command. Most are allocations of modest blocks at power-of-two or
  // arbitrary alignments, mixed with pops; the rest are clears, the spare code and
  // malformed allocations, some with sizes beyond the region.
  task automatic random_command(output logic [CMD_W-1:0] cmd, output logic [SIZE_W-1:0] size,
                                output logic [ALIGN_W-1:0] align);
    int pick;
    int shape;
    pick  = $urandom_range(0, 99);
    shape = $urandom_range(0, 9);
    if (shape < 5) begin
      align = ALIGN_W'(1 << $urandom_range(0, 15));
    end else if (shape < 8) begin
      align = ALIGN_W'($urandom_range(1, 65535));
    end else begin
      align = ALIGN_W'($urandom_range(1, 16));
    end
    shape = $urandom_range(0, 19);
    if (shape == 0) begin
      size = SIZE_W'($urandom_range(1, REGION_BYTES));
    end else if (shape == 1) begin
      size = SIZE_W'($urandom);
    end else begin
      size = SIZE_W'($urandom_range(1, 512));
    end
    if (pick < 55) begin
      cmd = CMD_ALLOC;
    end else if (pick < 80) begin
      cmd = CMD_POP;
    end else if (pick < 83) begin
      cmd = CMD_CLEAR;
    end else if (pick < 86) begin
      cmd = CMD_UNUSED;
    end else if (pick < 93) begin
      cmd = CMD_ALLOC;
      if ($urandom_range(0, 1) == 0) begin
        size = '0;
      end else begin
        align = '0;
      end
    end else begin
      cmd   = CMD_ALLOC;
      size  = SIZE_W'($urandom);
      align = ALIGN_W'($urandom);
    end
  endtask

  // Writes the base address with a setup and an access cycle, then reads it back.
  task automatic write_base_address(input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= REG_BASE_ADDRESS;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    base_addr = value;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== value) begin
      $display("%0t: base_address read back expected %h actual %h", $time, value, cfg_prdata);
      fail_count++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Stimulus: reset, the directed table, then phases of random commands, each
  // under a new base address written while nothing is in flight.
  initial begin
    logic [CMD_W-1:0]   cmd;
    logic [SIZE_W-1:0]  size;
    logic [ALIGN_W-1:0] align;
    alloc_result_t      typed_result;
    phase_bases[3] = $urandom;
    phase_bases[5] = $urandom;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      typed_result = {directed_rows[i].want_status, directed_rows[i].want_address,
                      directed_rows[i].want_entries, directed_rows[i].want_bytes};
      for (int k = 0; k < directed_rows[i].reps; k++) begin
        send_command(directed_rows[i].cmd, directed_rows[i].size, directed_rows[i].align,
                     directed_rows[i].typed, typed_result);
        sender_gap();
      end
    end

    for (int p = 0; p < 8; p++) begin
      // The sender pauses here until every owed result has come back.
      in_tvalid <= 1'b0;
      while (owed_results.size() != 0) @(posedge clk);
      // One phase runs with no idling on either side.
      tx_steady = (p == 3);
      rx_steady <= (p == 3);
      write_base_address(phase_bases[p]);

      // Every other phase starts by filling the size stack past its top with small
      // blocks, so that the full-stack answer is reached under many base addresses.
      if (p % 2 == 0) begin
        send_command(CMD_CLEAR, '0, '0, 1'b0, '0);
        sender_gap();
        repeat (MAX_ENTRIES + 2) begin
          send_command(CMD_ALLOC, SIZE_W'($urandom_range(1, 64)),
                       ALIGN_W'(1 << $urandom_range(0, 3)), 1'b0, '0);
          sender_gap();
        end
      end

      repeat (RANDOM_PER_PHASE) begin
        random_command(cmd, size, align);
        send_command(cmd, size, align, 1'b0, '0);
        sender_gap();
      end
    end

    in_tvalid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Receiver back-pressure. Once, after some traffic, it holds off for a long
  // stretch so that the block fills and stalls its input; otherwise it stalls
  // briefly at random, with an occasional longer pause.
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold    <= rx_hold - 1;
      out_tready <= 1'b0;
    end else if (!long_hold_done && result_beats >= 150) begin
      long_hold_done <= 1'b1;
      rx_hold        <= 400;
      out_tready     <= 1'b0;
    end else if (rx_steady) begin
      out_tready <= 1'b1;
    end else begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3: begin
          out_tready <= 1'b0;
          rx_hold    <= $urandom_range(0, 3);
        end
        4: begin
          out_tready <= 1'b0;
          rx_hold    <= $urandom_range(10, 60);
        end
        default: out_tready <= 1'b1;
      endcase
    end
  end

  // Each result beat is checked field by field against the oldest owed result.
  always @(posedge clk) begin
    alloc_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      result_beats <= result_beats + 1;
      if (owed_results.size() == 0) begin
        $display("%0t: result beat with none owed, status %0d address %h", $time,
                 out_tuser, out_tdata[31:0]);
        fail_count++;
      end else begin
        want = owed_results.pop_front();
        if (out_tuser !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_tuser);
          fail_count++;
        end
        if (out_tdata[31:0] !== want.address) begin
          $display("%0t: address expected %h actual %h", $time, want.address,
                   out_tdata[31:0]);
          fail_count++;
        end
        if (out_tdata[38:32] !== want.entries) begin
          $display("%0t: entries_used expected %0d actual %0d", $time, want.entries,
                   out_tdata[38:32]);
          fail_count++;
        end
        if (out_tdata[55:39] !== want.bytes) begin
          $display("%0t: bytes_used expected %0d actual %0d", $time, want.bytes,
                   out_tdata[55:39]);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: a long run of cycles with no beat on either channel ends the run.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

endmodule
